[hw/rtl/vac36_pkg.sv]
// Shared types, constants and symbol helpers for the alphanumeric Vigenere cipher.
package vac36_pkg;

    localparam int KPOS_W = 5;
    localparam int KLEN_W = 6;
    localparam int SYM_W  = 6;
    localparam int BYTE_W = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_REGS = 4;

    localparam logic [KLEN_W-1:0] KEY_MAX     = 6'd32;
    localparam logic [SYM_W-1:0]  ALPHA_SIZE  = 6'd36;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DECRYPT_MODE = 3'd0,
        REG_KEY_LENGTH   = 3'd1,
        REG_KEY_BYTES_0  = 3'd2,
        REG_KEY_BYTES_1  = 3'd3,
        REG_KEY_BYTES_2  = 3'd4,
        REG_KEY_BYTES_3  = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] idx;
    } sym_t;

    // One classified item on its way from front to back.
    typedef struct packed {
        logic              is_sym;
        logic [SYM_W-1:0]  sym_idx;
        logic [SYM_W-1:0]  shift;
        logic              decrypt;
        logic [BYTE_W-1:0] byte_val;
    } q_entry_t;

    // '0'..'9' -> 0..9, 'A'..'Z' -> 10..35, anything else is not a symbol.
    function automatic sym_t sym_index(input logic [BYTE_W-1:0] c);
        sym_t r;
        logic [BYTE_W-1:0] d;
        r = '0;
        d = '0;
        if (c >= 8'd48 && c <= 8'd57)
        begin
            d = c - 8'd48;
            r.ok = 1'b1;
            r.idx = d[SYM_W-1:0];
        end
        else if (c >= 8'd65 && c <= 8'd90)
        begin
            d = c - 8'd55;
            r.ok = 1'b1;
            r.idx = d[SYM_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] sym_char(input logic [SYM_W-1:0] s);
        logic [BYTE_W-1:0] w;
        w = {2'b00, s};
        return (s < 6'd10) ? (w + 8'd48) : (w + 8'd55);
    endfunction

endpackage

[hw/rtl/vac36_front.sv]
// Front end: config registers, case folding, classification, key lookup and key position.
module vac36_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [vac36_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [vac36_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    input  logic [vac36_pkg::BYTE_W-1:0]       in_byte,
    input  logic                               q_full,
    output logic                               in_ready,
    output logic                               q_push,
    output vac36_pkg::q_entry_t                q_data
);
    import vac36_pkg::*;

    logic                        decrypt_reg;
    logic [KLEN_W-1:0]           key_len_reg;
    logic [CFG_DATA_W-1:0]       key_reg [KEY_REGS];
    logic [KPOS_W-1:0]           key_pos_reg;
    logic [KPOS_W-1:0]           key_pos_next;

    logic [BYTE_W-1:0]           folded;
    logic [BYTE_W-1:0]           key_byte;
    logic [KLEN_W-1:0]           eff_len;
    logic [KLEN_W-1:0]           pos_inc;
    sym_t                        txt_sym;
    sym_t                        key_sym;
    logic                        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_reg <= 1'b0;
            key_len_reg <= 6'd1;
            for (int i = 0; i < KEY_REGS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_e'(cfg_addr))
                REG_DECRYPT_MODE: decrypt_reg <= cfg_data[0];
                REG_KEY_LENGTH:   key_len_reg <= cfg_data[KLEN_W-1:0];
                REG_KEY_BYTES_0:  key_reg[0]  <= cfg_data;
                REG_KEY_BYTES_1:  key_reg[1]  <= cfg_data;
                REG_KEY_BYTES_2:  key_reg[2]  <= cfg_data;
                REG_KEY_BYTES_3:  key_reg[3]  <= cfg_data;
                default: ;
            endcase
        end
    end

    // 96..127 fold down to 64..95 by clearing bit 5
    assign folded  = (in_byte[7:5] == 3'b011) ? (in_byte & 8'hDF) : in_byte;
    assign txt_sym = sym_index(folded);
    assign key_byte = key_reg[key_pos_reg[4:3]][{key_pos_reg[2:0], 3'b000} +: BYTE_W];
    assign key_sym = sym_index(key_byte);

    always_comb
    begin
        if (key_len_reg == '0)
            eff_len = 6'd1;
        else if (key_len_reg > KEY_MAX)
            eff_len = KEY_MAX;
        else
            eff_len = key_len_reg;
    end

    assign pos_inc = {1'b0, key_pos_reg} + 6'd1;

    always_comb
    begin
        key_pos_next = key_pos_reg;
        if (accept && txt_sym.ok)
        begin
            key_pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[KPOS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_pos_reg <= '0;
        else
            key_pos_reg <= key_pos_next;
    end

    always_comb
    begin
        q_data.is_sym   = txt_sym.ok;
        q_data.sym_idx  = txt_sym.idx;
        q_data.shift    = key_sym.ok ? key_sym.idx : '0;
        q_data.decrypt  = decrypt_reg;
        q_data.byte_val = folded;
    end

`ifndef NO_ASSERTIONS
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !txt_sym.ok && !cfg_valid) |=> $stable(key_pos_reg))
        else $error("key position moved on a non-symbol item");
    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && txt_sym.ok && (pos_inc >= eff_len)) |=> (key_pos_reg == '0))
        else $error("key position failed to wrap");
`endif

endmodule

[hw/rtl/vac36_queue.sv]
// Short FIFO between the classifying front end and the shifting back end.
module vac36_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  vac36_pkg::q_entry_t  push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 empty,
    output vac36_pkg::q_entry_t  head
);
    import vac36_pkg::*;

    q_entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from an empty queue");
`endif

endmodule

[hw/rtl/vac36_back.sv]
// Back end: mod-36 shift of symbols and the registered output stage.
module vac36_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  vac36_pkg::q_entry_t           q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vac36_pkg::BYTE_W-1:0]  out_byte
);
    import vac36_pkg::*;

    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [SYM_W-1:0]     addend;
    logic [SYM_W:0]       sum;
    logic [SYM_W:0]       wrapped;
    logic [BYTE_W-1:0]    result;

    // decrypt adds (36 - shift), so one conditional subtract covers both modes
    assign addend  = q_head.decrypt ? (ALPHA_SIZE - q_head.shift) : q_head.shift;
    assign sum     = {1'b0, q_head.sym_idx} + {1'b0, addend};
    assign wrapped = (sum >= {1'b0, ALPHA_SIZE}) ? (sum - {1'b0, ALPHA_SIZE}) : sum;
    assign result  = q_head.is_sym ? sym_char(wrapped[SYM_W-1:0]) : q_head.byte_val;

    assign q_pop     = !q_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (q_pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_byte_reg <= result;
    end

endmodule

[hw/rtl/vigenere_alnum36_cipher.sv]
// Top level of the 36-symbol alphanumeric Vigenere stream cipher.
//
// Usage:
//   Text bytes enter on s_axis (tdata = text_byte), one item per byte.
//   Ciphered bytes leave on m_axis (tdata = cipher_byte), one per input.
//   Config writes on cfg_*: addr 0 decrypt_mode, 1 key_length (1..32),
//   2..5 key bytes 0..31, eight per word, lowest byte in low bits.
//   cfg_ready is always high; write only while no items are in flight.
// Timing:
//   An accepted item is queued, then popped into the output register that
//   drives m_axis. Throughput is one item per cycle while m_axis_tready
//   stays high: the front end folds, classifies and looks up the key byte
//   in the accept cycle; the back end adds mod 36 and loads the output register on a pop.
//   A two-entry queue sits between them, so the front keeps taking items
//   while a result waits; s_axis_tready drops only when the queue is full.
// Reset (rst_n low, async): key position 0, encrypt mode, key length 1,
//   key bytes zero, queue and output register empty.
// Stall: m_axis holds its item while m_axis_tready is low; at most two
//   more items are buffered before s_axis_tready goes low.
module vigenere_alnum36_cipher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] text_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [7:0] cipher_byte
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vac36_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [vac36_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import vac36_pkg::*;

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    q_entry_t  q_in;
    q_entry_t  q_head;

    assign cfg_ready = 1'b1;

    vac36_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .q_full    (q_full),
        .in_ready  (s_axis_tready),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    vac36_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    vac36_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata)
    );

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the alphanumeric Vigenere stream cipher.
`timescale 1ns / 1ps

module tb_top;
    import vac36_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int DRAIN_LIMIT    = 50;     // cycles allowed for the tail to drain
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ITEMS    = 92;

    localparam logic [7:0] CH_0 = "0";
    localparam logic [7:0] CH_9 = "9";
    localparam logic [7:0] CH_A = "A";
    localparam logic [7:0] CH_Z = "Z";
    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] LOWER_LO = 8'd96;
    localparam logic [7:0] LOWER_HI = 8'd127;
    localparam logic [7:0] CASE_GAP = 8'd32;
    localparam int ALPHABET = 36;
    localparam int DIGITS   = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the cipher's registers and key pointer (reset values).
    logic        mode_dec = 1'b0;
    logic [5:0]  key_len_reg = 6'd1;
    logic [63:0] key_word [4] = '{default: '0};
    logic [4:0]  key_pos = '0;

    logic [7:0] pending_text [$];   // plaintext waiting for the driver
    logic [7:0] cipher_expect [$];  // predicted output bytes, oldest first

    int  text_sent = 0;
    int  text_taken_cnt = 0;
    int  errors = 0;
    int  idle_cycles = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    logic text_accepted = 1'b0;
    logic cfg_taken = 1'b0;
    logic hold_arm = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    vigenere_alnum36_cipher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] text_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [7:0] cipher_byte
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // {is_symbol, rank}: digits rank 0..9, upper-case letters 10..35.
    function automatic logic [6:0] alnum_rank(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return {1'b1, 6'(c - CH_0)};
        if (c >= CH_A && c <= CH_Z)
            return {1'b1, 6'(c - CH_A + DIGITS)};
        return '0;
    endfunction

    // Predicts one output byte and advances the shadow key pointer.
    task automatic cipher_step(input logic [7:0] raw, output logic [7:0] res);
        logic [7:0] c;
        logic [7:0] kb;
        logic [6:0] t_rank;
        logic [6:0] k_rank;
        int shift;
        int s;
        int span;
        c = (raw >= LOWER_LO && raw <= LOWER_HI) ? raw - CASE_GAP : raw;
        t_rank = alnum_rank(c);
        res = c;
        if (t_rank[6])
        begin
            kb = key_word[key_pos[4:3]][key_pos[2:0]*8 +: 8];
            k_rank = alnum_rank(kb);
            // non-symbol key bytes (lower case too) shift by zero
            shift = k_rank[6] ? int'(k_rank[5:0]) : 0;
            if (mode_dec)
                s = (int'(t_rank[5:0]) + ALPHABET - shift) % ALPHABET;
            else
                s = (int'(t_rank[5:0]) + shift) % ALPHABET;
            res = (s < DIGITS) ? CH_0 + 8'(s) : CH_A + 8'(s - DIGITS);
            // length 0 acts as 1, anything above 32 as 32
            span = (key_len_reg == 0) ? 1 : (key_len_reg > 32) ? 32 : int'(key_len_reg);
            // a pointer left beyond a shortened key still gets used once, then wraps
            key_pos = (int'(key_pos) + 1 >= span) ? '0 : key_pos + 5'd1;
        end
    endtask

    task automatic queue_text(input logic [7:0] b);
        pending_text.push_back(b);
        text_sent++;
    endtask

    // Called at a falling edge; returns at the falling edge after the write lands.
    task automatic cfg_write(input cfg_reg_e idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= d;
        do
            @(negedge clk);
        while (!cfg_taken);
    endtask

    // Every queued item accepted and every result back, plus a little slack.
    task automatic wait_settled();
        do
            @(negedge clk);
        while (text_taken_cnt != text_sent || cipher_expect.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    // Sender: a valid item stays up until taken, then the next one may follow.
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || text_accepted)
        begin
            if (pending_text.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_text.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off when armed.
    always @(negedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Handshake monitor: tracks config writes, predicts, and checks outputs.
    always @(posedge clk)
    begin : scoreboard
        logic [7:0] want;
        text_accepted <= s_axis_tvalid && s_axis_tready;
        cfg_taken     <= cfg_valid && cfg_ready;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_DECRYPT_MODE: mode_dec    = cfg_data[0];
                REG_KEY_LENGTH:   key_len_reg = cfg_data[5:0];
                REG_KEY_BYTES_0:  key_word[0] = cfg_data;
                REG_KEY_BYTES_1:  key_word[1] = cfg_data;
                REG_KEY_BYTES_2:  key_word[2] = cfg_data;
                REG_KEY_BYTES_3:  key_word[3] = cfg_data;
                default: ;
            endcase
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (cipher_expect.size() == 0)
            begin
                if (errors < 10)
                    $display("%0t: unexpected output byte %02h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = cipher_expect.pop_front();
                if (m_axis_tdata !== want)
                begin
                    if (errors < 10)
                        $display("%0t: cipher_byte mismatch, expected %02h got %02h",
                                 $time, want, m_axis_tdata);
                    errors++;
                end
            end
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            cipher_step(s_axis_tdata, want);
            cipher_expect.push_back(want);
            text_taken_cnt++;
        end
    end

    // Watchdog: too long without any handshake means the block hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int p;
        int k;
        int r;
        int n;
        logic [63:0] w;
        logic [7:0] b;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: key mixes digits, letters, lower case and junk bytes.
        cfg_write(REG_DECRYPT_MODE, 64'd0);
        cfg_write(REG_KEY_LENGTH, 64'd32);
        cfg_write(REG_KEY_BYTES_0, {"M", 8'hFF, "#", "z", "Z", "A", "9", "0"});
        cfg_write(REG_KEY_BYTES_1, {8{"Z"}});
        cfg_write(REG_KEY_BYTES_2, 64'd0);
        cfg_write(REG_KEY_BYTES_3, {64{1'b1}});
        cfg_valid <= 1'b0;
        @(posedge clk);
        tx_idle_pct = 34;
        rx_idle_pct = 71;
        // field extremes, case folding, the bytes just outside both symbol ranges
        queue_text(8'h00);
        queue_text(8'hFF);
        queue_text("0");
        queue_text("9");
        queue_text("A");
        queue_text("Z");        // Z + Z wraps past the end of the alphabet
        queue_text("a");
        queue_text("z");
        queue_text(8'h60);      // folds to '@', not a symbol
        queue_text(8'h7F);
        queue_text(8'h7B);      // folds to '['
        queue_text(8'h80);
        queue_text("/");
        queue_text(":");
        queue_text("@");
        queue_text("[");
        wait_settled();

        // Shorten the key below the current pointer, decrypt.
        cfg_write(REG_DECRYPT_MODE, 64'd1);
        cfg_write(REG_KEY_LENGTH, 64'd3);
        cfg_valid <= 1'b0;
        @(posedge clk);
        queue_text("0");
        queue_text("Z");
        queue_text("z");
        queue_text("5");
        queue_text("K");
        wait_settled();

        // Key length zero behaves as one.
        cfg_write(REG_KEY_LENGTH, 64'd0);
        cfg_valid <= 1'b0;
        @(posedge clk);
        queue_text("A");
        queue_text("B");
        wait_settled();

        // Key length 63 saturates at 32.
        cfg_write(REG_DECRYPT_MODE, 64'd0);
        cfg_write(REG_KEY_LENGTH, 64'd63);
        cfg_valid <= 1'b0;
        @(posedge clk);
        queue_text("Q");
        queue_text("R");
        wait_settled();

        // Random phases, each with a fresh (partial) configuration.
        for (p = 0; p < RAND_PHASES; p++)
        begin
            cfg_write(REG_DECRYPT_MODE, 64'($urandom_range(0, 1)));
            r = $urandom_range(0, 19);
            case (r)
                0: n = 1;
                1: n = 32;
                2: n = 0;
                3: n = $urandom_range(33, 63);
                default: n = $urandom_range(1, 32);
            endcase
            cfg_write(REG_KEY_LENGTH, 64'(n));
            for (k = 0; k < 4; k++)
            begin
                if (p == 0 || $urandom_range(0, 2) != 0)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        w = '0;
                    else if (r == 1)
                        w = {64{1'b1}};
                    else
                    begin
                        for (n = 0; n < 8; n++)
                        begin
                            r = $urandom_range(0, 9);
                            if (r < 5)
                                b = CH_A + 8'($urandom_range(0, 25));
                            else if (r < 8)
                                b = CH_0 + 8'($urandom_range(0, 9));
                            else if (r == 8)
                                b = CH_LA + 8'($urandom_range(0, 25));
                            else
                                b = 8'($urandom_range(0, 255));
                            w[n*8 +: 8] = b;
                        end
                    end
                    cfg_write(cfg_reg_e'(REG_KEY_BYTES_0 + k), w);
                end
            end
            cfg_valid <= 1'b0;
            @(posedge clk);
            // idling pattern: sender-light first, then receiver-light, then none
            if (p < RAND_PHASES / 3)
            begin
                tx_idle_pct = 34;
                rx_idle_pct = 71;
            end
            else if (p < 2 * RAND_PHASES / 3)
            begin
                tx_idle_pct = 71;
                rx_idle_pct = 34;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 9);
                if (r < 4)
                    b = CH_A + 8'($urandom_range(0, 25));
                else if (r < 6)
                    b = CH_LA + 8'($urandom_range(0, 25));
                else if (r < 8)
                    b = CH_0 + 8'($urandom_range(0, 9));
                else
                    b = 8'($urandom_range(0, 255));
                queue_text(b);
            end
            // full-rate sender against a stalled receiver backs the block up
            if (p == 2 * RAND_PHASES / 3)
                hold_arm = 1'b1;
            wait_settled();
        end

        do
            @(negedge clk);
        while (text_taken_cnt != text_sent);
        for (k = 0; k < DRAIN_LIMIT && cipher_expect.size() != 0; k++)
            @(negedge clk);
        if (cipher_expect.size() != 0)
        begin
            $display("%0d predicted output bytes never arrived", cipher_expect.size());
            errors += cipher_expect.size();
        end
        repeat (5) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
